[rtl/rgts_pkg.sv]
// Shared types and constants of the RGBA8 tile swizzler.
`default_nettype none

package rgts_pkg;

  // Fixed field widths
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned OFFSET_W = 22;
  localparam int unsigned CFG_IDX_W = 2;
  // Tile index bits left once the 64-byte tile offset is taken off
  localparam int unsigned TILE_W   = OFFSET_W - 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // take the input beat and step the raster counters
    logic calc;    // form the tile index
    logic emit;    // load pair writes into the output register
  } rgts_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic final_load;  // the last write of the pixel is loaded in this cycle
  } rgts_status_t;

endpackage

`default_nettype wire

[rtl/rgts_pixel_if.sv]
// Channel interface carrying one RGBA pixel per beat.
`default_nettype none

interface rgts_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

`default_nettype wire

[rtl/rgts_write_if.sv]
// Channel interface carrying one byte-pair write per beat.
`default_nettype none

interface rgts_write_if;
  logic        valid;
  logic        ready;
  logic [21:0] dest_offset;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic        last_write;
  logic        image_done;

  modport source (output valid, dest_offset, first_byte, second_byte, last_write,
                  image_done, input ready);
  modport sink   (input valid, dest_offset, first_byte, second_byte, last_write,
                  image_done, output ready);
endinterface

`default_nettype wire

[rtl/rgts_cfg_if.sv]
// Configuration write channel interface.
`default_nettype none

interface rgts_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/rgba8_tile_swizzler_top.sv]
// A taken pixel beat is registered, its tile index is formed in the calc state, and its
// pair writes (2 to 32) go through the single output register in the emit state, one
// write per cycle unless stalled; the next pixel is taken alongside the final write.
// Reset (rst_n low, synchronous): column and row counters clear, width and height return
// to one, and the output channel empties.
`default_nettype none

module rgba8_tile_swizzler_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  rgts_pixel_if.sink    in_pixel,
  rgts_write_if.source  out_write,
  rgts_cfg_if.sink      cfg_port
);
  import rgts_pkg::*;

  rgts_cmd_t    cmd;
  rgts_status_t status;

  // Configuration writes are always taken
  assign cfg_port.ready = 1'b1;

  rgts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pixel.valid),
    .in_ready (in_pixel.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rgts_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_port.valid),
    .cfg_index      (cfg_port.index),
    .cfg_data       (cfg_port.data),
    .pix_red        (in_pixel.red),
    .pix_green      (in_pixel.green),
    .pix_blue       (in_pixel.blue),
    .pix_alpha      (in_pixel.alpha),
    .cmd            (cmd),
    .status         (status),
    .wr_valid       (out_write.valid),
    .wr_ready       (out_write.ready),
    .wr_dest_offset (out_write.dest_offset),
    .wr_first_byte  (out_write.first_byte),
    .wr_second_byte (out_write.second_byte),
    .wr_last_write  (out_write.last_write),
    .wr_image_done  (out_write.image_done)
  );

endmodule

`default_nettype wire

[rtl/rgts_ctrl.sv]
// Controller state machine of the tile swizzler.
`default_nettype none

module rgts_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  rgts_pkg::rgts_status_t     status,
  output rgts_pkg::rgts_cmd_t        cmd
);
  import rgts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new pixel is taken when idle, or alongside the final write of the last one
  always_comb begin
    in_ready   = (state_r == ST_IDLE) || ((state_r == ST_EMIT) && status.final_load);
    cmd.accept = in_ready && in_valid;
    cmd.calc   = (state_r == ST_CALC);
    cmd.emit   = (state_r == ST_EMIT);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.final_load) begin
          state_nxt = cmd.accept ? ST_CALC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/rgts_dp.sv]
// Datapath of the tile swizzler: size registers, raster counters, tile address and output.
`default_nettype none

module rgts_dp #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration
  input  wire logic                            cfg_we,
  input  wire logic [rgts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rgts_pkg::SIZE_W-1:0]     cfg_data,
  // Pixel payload
  input  wire logic [rgts_pkg::CHAN_W-1:0]     pix_red,
  input  wire logic [rgts_pkg::CHAN_W-1:0]     pix_green,
  input  wire logic [rgts_pkg::CHAN_W-1:0]     pix_blue,
  input  wire logic [rgts_pkg::CHAN_W-1:0]     pix_alpha,
  // Controller link
  input  rgts_pkg::rgts_cmd_t                  cmd,
  output rgts_pkg::rgts_status_t               status,
  // Write channel
  output logic                                 wr_valid,
  input  wire logic                            wr_ready,
  output logic [rgts_pkg::OFFSET_W-1:0]        wr_dest_offset,
  output logic [rgts_pkg::CHAN_W-1:0]          wr_first_byte,
  output logic [rgts_pkg::CHAN_W-1:0]          wr_second_byte,
  output logic                                 wr_last_write,
  output logic                                 wr_image_done
);
  import rgts_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = RW + WW;

  // Size registers
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(1);
      height_r <= SIZE_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Sizes in use: zero counts as one, larger values are capped
  logic [31:0] w_wide;
  logic [31:0] h_wide;
  logic [WW-1:0] w_use;
  logic [HW-1:0] h_use;
  logic [WW-1:0] tiles_x;

  always_comb begin
    if (width_r == '0) begin
      w_wide = 32'd1;
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_wide = 32'(MAX_WIDTH);
    end else begin
      w_wide = 32'(width_r);
    end
    if (height_r == '0) begin
      h_wide = 32'd1;
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_wide = 32'(MAX_HEIGHT);
    end else begin
      h_wide = 32'(height_r);
    end
    w_use   = WW'(w_wide);
    h_use   = HW'(h_wide);
    tiles_x = WW'((w_wide + 32'd3) >> 2);
  end

  // Raster counters and the position of the accepted pixel
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] x_cur;
  logic [RW-1:0] y_cur;
  logic          right_cur;
  logic          bottom_cur;

  always_comb begin
    x_cur      = (32'(col_r) >= 32'(w_use)) ? '0 : col_r;
    y_cur      = (32'(row_r) >= 32'(h_use)) ? '0 : row_r;
    right_cur  = (32'(x_cur) == (32'(w_use) - 32'd1));
    bottom_cur = (32'(y_cur) == (32'(h_use) - 32'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if (right_cur) begin
        col_r <= '0;
        row_r <= bottom_cur ? '0 : RW'(y_cur + RW'(1));
      end else begin
        col_r <= CW'(x_cur + CW'(1));
      end
    end
  end

  // Pixel and position registers
  logic [CHAN_W-1:0] red_r, green_r, blue_r, alpha_r;
  logic [CW-1:0]     x_r;
  logic [RW-1:0]     y_r;
  logic              right_r;
  logic              bottom_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      red_r    <= pix_red;
      green_r  <= pix_green;
      blue_r   <= pix_blue;
      alpha_r  <= pix_alpha;
      x_r      <= x_cur;
      y_r      <= y_cur;
      right_r  <= right_cur;
      bottom_r <= bottom_cur;
    end
  end

  // Tile index: all writes of one pixel fall in the same tile
  logic [PW-1:0]     tile_prod;
  logic [TILE_W-1:0] tile_r;

  always_comb begin
    tile_prod = PW'(y_r >> 2) * PW'(tiles_x);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      tile_r <= TILE_W'(32'(tile_prod) + 32'(x_r >> 2));
    end
  end

  // Walk over the covered texels, AR then GB pair at each
  logic [1:0] sx_r, sy_r;
  logic       half_r;
  logic [1:0] x_lo, y_lo, x_end, y_end;
  logic       last_pos;
  logic       load;

  always_comb begin
    x_lo     = 2'(x_r);
    y_lo     = 2'(y_r);
    x_end    = right_r ? 2'd3 : x_lo;
    y_end    = bottom_r ? 2'd3 : y_lo;
    last_pos = half_r && (sx_r == x_end) && (sy_r == y_end);
    load     = cmd.emit && (!wr_valid || wr_ready);
    status.final_load = load && last_pos;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sx_r   <= 2'(x_cur);
      sy_r   <= 2'(y_cur);
      half_r <= 1'b0;
    end else if (load) begin
      if (!half_r) begin
        half_r <= 1'b1;
      end else begin
        half_r <= 1'b0;
        if (sx_r == x_end) begin
          sx_r <= x_lo;
          sy_r <= sy_r + 2'd1;
        end else begin
          sx_r <= sx_r + 2'd1;
        end
      end
    end
  end

  // Output register
  logic                valid_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [CHAN_W-1:0]   first_r, second_r;
  logic                last_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (wr_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      offset_r <= {tile_r, half_r, sy_r, sx_r, 1'b0};
      first_r  <= half_r ? green_r : alpha_r;
      second_r <= half_r ? blue_r : red_r;
      last_r   <= last_pos;
      done_r   <= last_pos && right_r && bottom_r;
    end
  end

  assign wr_valid       = valid_r;
  assign wr_dest_offset = offset_r;
  assign wr_first_byte  = first_r;
  assign wr_second_byte = second_r;
  assign wr_last_write  = last_r;
  assign wr_image_done  = done_r;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench of the RGBA8 4x4 tile swizzler, with its own tiling predictor.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgts_pkg::*;

  localparam int unsigned MAX_W      = 1024;
  localparam int unsigned MAX_H      = 1024;
  localparam int unsigned TILE_DIM   = 4;
  localparam int unsigned DIM_MASK   = 3;
  localparam int unsigned TILE_BYTES = 64;
  localparam int unsigned GB_OFFSET  = 32;

  // Indexes that name no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Pacing modes: no idling, sender idle, receiver stalling, both lightly.
  localparam int SENDER_IDLE_PCT[4]   = '{0, 63, 0, 6};
  localparam int RECEIVER_STALL_PCT[4] = '{0, 0, 63, 6};

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] dest_offset;
    logic [CHAN_W-1:0]   first_byte;
    logic [CHAN_W-1:0]   second_byte;
    logic                last_write;
    logic                image_done;
  } pair_write_t;

  logic clk = 1'b0;
  logic rst_n;

  rgts_pixel_if pixel_ch ();
  rgts_write_if write_ch ();
  rgts_cfg_if   cfg_ch ();

  rgba8_tile_swizzler_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pixel (pixel_ch),
    .out_write(write_ch),
    .cfg_port (cfg_ch)
  );

  always #2 clk = ~clk;

  // Predictor state: size registers as written, and the raster position.
  logic [SIZE_W-1:0] width_reg  = 1;
  logic [SIZE_W-1:0] height_reg = 1;
  int unsigned       col_pos    = 0;
  int unsigned       row_pos    = 0;

  pixel_t      pixel_backlog[$];
  pair_write_t writes_due[$];
  pixel_t      pixel_on_bus;
  pair_write_t due_write;
  int          pixels_pending = 0;
  int          write_errors   = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;

  // A zero size counts as one and an oversized one is held at the maximum.
  function automatic int unsigned size_used(input logic [SIZE_W-1:0] value,
                                            input int unsigned limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  // Works out every pair write of one pixel, edge replication included, and
  // steps the raster position.
  function automatic void swizzle_pixel(input pixel_t pix);
    int unsigned w, h, tiles_x, x_end, y_end, base, px, py;
    bit at_right, at_bottom, last;
    pair_write_t ar, gb;
    w = size_used(width_reg, MAX_W);
    h = size_used(height_reg, MAX_H);
    tiles_x = (w + DIM_MASK) / TILE_DIM;
    // A position left beyond a lowered size starts again from zero.
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    at_right  = (col_pos == w - 1);
    at_bottom = (row_pos == h - 1);
    x_end = at_right ? (col_pos | DIM_MASK) : col_pos;
    y_end = at_bottom ? (row_pos | DIM_MASK) : row_pos;
    for (py = row_pos; py <= y_end; py++) begin
      for (px = col_pos; px <= x_end; px++) begin
        base = ((py / TILE_DIM) * tiles_x + px / TILE_DIM) * TILE_BYTES
             + (((py & DIM_MASK) * TILE_DIM) + (px & DIM_MASK)) * 2;
        last = (py == y_end) && (px == x_end);
        ar.dest_offset = base[OFFSET_W-1:0];
        ar.first_byte  = pix.alpha;
        ar.second_byte = pix.red;
        ar.last_write  = 1'b0;
        ar.image_done  = 1'b0;
        writes_due.push_back(ar);
        gb.dest_offset = base[OFFSET_W-1:0] + GB_OFFSET[OFFSET_W-1:0];
        gb.first_byte  = pix.green;
        gb.second_byte = pix.blue;
        gb.last_write  = last;
        gb.image_done  = last && at_right && at_bottom;
        writes_due.push_back(gb);
      end
    end
    if (at_right) begin
      col_pos = 0;
      row_pos = at_bottom ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      write_errors++;
    end
  endfunction

  // Pixel driver: predicts on each accepted beat, then offers the next pixel.
  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_ch.valid <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        pixels_pending--;
        swizzle_pixel(pixel_on_bus);
      end
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (pixel_backlog.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          pixel_on_bus = pixel_backlog.pop_front();
          pixel_ch.valid <= 1'b1;
          pixel_ch.red   <= pixel_on_bus.red;
          pixel_ch.green <= pixel_on_bus.green;
          pixel_ch.blue  <= pixel_on_bus.blue;
          pixel_ch.alpha <= pixel_on_bus.alpha;
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Write monitor: checks each accepted beat against the oldest expected write.
  always @(posedge clk) begin
    if (!rst_n) begin
      write_ch.ready <= 1'b0;
    end else begin
      if (write_ch.valid && write_ch.ready) begin
        if (writes_due.size() == 0) begin
          $error("unexpected pair write to offset 0x%0h", write_ch.dest_offset);
          write_errors++;
        end else begin
          due_write = writes_due.pop_front();
          compare_field("dest_offset", due_write.dest_offset, write_ch.dest_offset);
          compare_field("first_byte", due_write.first_byte, write_ch.first_byte);
          compare_field("second_byte", due_write.second_byte, write_ch.second_byte);
          compare_field("last_write", due_write.last_write, write_ch.last_write);
          compare_field("image_done", due_write.image_done, write_ch.image_done);
        end
      end
      write_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic set_pace(input int mode);
    src_idle_pct   = SENDER_IDLE_PCT[mode];
    sink_stall_pct = RECEIVER_STALL_PCT[mode];
  endtask

  // Writes one register and mirrors it in the predictor once the beat is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = value;
    else if (idx == REG_IMAGE_HEIGHT) height_reg = value;
  endtask

  task automatic queue_pixel(input pixel_t pix);
    pixel_backlog.push_back(pix);
    pixels_pending++;
  endtask

  task automatic queue_pixels(input int count);
    repeat (count) queue_pixel(pixel_t'($urandom));
  endtask

  // Holds the sender back until every expected write has arrived, then lets
  // the pipeline empty.
  task automatic settle();
    while (pixels_pending != 0 || writes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return $urandom_range(2047, MAX_W + 1);
      2:       return MAX_W;
      default: return $urandom_range(9, 1);
    endcase
  endfunction

  initial begin
    int phase, random_count, area, n;
    pixel_ch.valid = 1'b0;
    pixel_ch.red   = '0;
    pixel_ch.green = '0;
    pixel_ch.blue  = '0;
    pixel_ch.alpha = '0;
    write_ch.ready = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_IMAGE_WIDTH;
    cfg_ch.data    = '0;
    rst_n          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sizes come out of reset as one by one, so every pixel is a whole image.
    set_pace(0);
    queue_pixel(pixel_t'(32'h0000_0000));
    queue_pixel(pixel_t'(32'hFFFF_FFFF));
    settle();

    // Zero sizes behave as one; spare indexes change nothing.
    set_pace(1);
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_SPARE_2, 11'h7FF);
    write_reg(REG_SPARE_3, 11'h005);
    queue_pixel(pixel_t'(32'hA55A_0FF0));
    settle();

    // A whole small image with a ragged right edge and a ragged bottom.
    set_pace(2);
    write_reg(REG_IMAGE_WIDTH, 5);
    write_reg(REG_IMAGE_HEIGHT, 2);
    queue_pixel(pixel_t'(32'h5AA5_F00F));
    queue_pixels(9);
    settle();

    // Part of an image, a pause, then a lowered width leaves the column beyond it.
    set_pace(3);
    write_reg(REG_IMAGE_WIDTH, 8);
    write_reg(REG_IMAGE_HEIGHT, 3);
    queue_pixels(3);
    settle();
    queue_pixels(2);
    settle();
    write_reg(REG_IMAGE_WIDTH, 3);
    queue_pixels(2);
    settle();

    // Oversized registers are held at the maximum; then two pixels of a one-row image at full width.
    set_pace(0);
    write_reg(REG_IMAGE_WIDTH, 11'h7FF);
    write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
    queue_pixels(3);
    settle();
    write_reg(REG_IMAGE_WIDTH, MAX_W);
    write_reg(REG_IMAGE_HEIGHT, 1);
    queue_pixels(2);
    settle();

    // Random phases: mostly whole small images, sometimes cut short or carried on.
    phase = 0;
    random_count = 0;
    while (random_count < 75) begin
      set_pace(phase % 4);
      if (phase % 5 != 4) begin
        write_reg(REG_IMAGE_WIDTH, pick_size());
        write_reg(REG_IMAGE_HEIGHT, pick_size());
      end
      area = size_used(width_reg, MAX_W) * size_used(height_reg, MAX_H);
      n = (area <= 24) ? area : $urandom_range(16, 4);
      if ($urandom_range(3) == 0) n = $urandom_range(n, 1);
      queue_pixels(n);
      random_count += n;
      phase++;
      settle();
    end

    repeat (10) @(posedge clk);
    if (write_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/rgts_pkg.sv
rtl/rgts_pixel_if.sv
rtl/rgts_write_if.sv
rtl/rgts_cfg_if.sv
rtl/rgts_ctrl.sv
rtl/rgts_dp.sv
rtl/rgba8_tile_swizzler_top.sv
tb/tb.sv
